>>> rtl/assert_macros.svh
// assertion macros used by the checker file cfr_checker.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent assertion on the usual clock and reset names
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

>>> rtl/cfr_pkg.sv
// types, constants and codes for the coordinate frame receiver
// no dependencies; imported by every module of the block but cfr_fifo
`default_nettype none

package cfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CoordW  = 15;
  localparam int unsigned SumW    = 22;
  localparam int unsigned FoldW   = 20;
  localparam int unsigned PosW    = 4;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [6:0]       LenExpect  = 7'd96;
  localparam logic [ByteW-1:0] StartReset = 8'd240;
  localparam logic [ByteW-1:0] DestReset  = 8'd128;
  localparam logic [ByteW-1:0] EndReset   = 8'd15;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_DEST  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_END   = 3'd4,
    ST_BAD_SUM   = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START = 2'd0,
    REG_DEST  = 2'd1,
    REG_END   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [ByteW-1:0]   data;
  } cfg_wr_t;

  // classified frame handed from front to back
  typedef struct packed {
    status_e           status;
    logic [SumW-1:0]   sum;
    logic [CoordW-1:0] x_raw;
    logic [CoordW-1:0] y_raw;
    logic [CoordW-1:0] z_raw;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_push_t;

  // finished result word
  typedef struct packed {
    status_e                  status;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/cfr_fifo.sv
// small register-based queue used between the stages
// depends on nothing but its parameters
`default_nettype none

module cfr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cfr_front.sv
// front end: frame state machine, byte store, running checksum, config registers
// depends on cfr_pkg
`default_nettype none

module cfr_front
  import cfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             byte_valid_i,
  input  logic [ByteW-1:0] byte_i,
  output rec_push_t        push_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DEST    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_END     = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] start_q, dest_q, end_q;
  logic [ByteW-1:0] frame_q [10];
  logic             store_en;
  logic [PosW-1:0]  store_pos;

  // weight of one frame byte in the end-around-carry sum
  function automatic logic [SumW-1:0] sum_part(input logic [PosW-1:0] pos,
                                               input logic [ByteW-1:0] b);
    logic [SumW-1:0] r;
    case (pos)
      4'd0, 4'd5: r = {14'd0, b};
      4'd1, 4'd6: r = {6'd0, b, 8'd0};
      4'd2, 4'd7: r = {2'd0, b[3:0], 12'd0, b[7:4]};
      4'd3, 4'd8: r = {10'd0, b, 4'd0};
      4'd4, 4'd9: r = {2'd0, b, 12'd0};
      default:    r = '0;
    endcase
    return r;
  endfunction

  // next phase, store control and classified word
  always_comb begin
    phase_d          = phase_q;
    cnt_d            = cnt_q;
    sum_d            = sum_q;
    store_en         = 1'b0;
    store_pos        = '0;
    push_o.valid     = 1'b0;
    push_o.rec       = '0;
    push_o.rec.status = ST_OK;
    if (byte_valid_i) begin
      case (phase_q)
        PH_DEST: begin
          if (byte_i != dest_q) begin
            push_o.valid      = 1'b1;
            push_o.rec.status = ST_BAD_DEST;
            phase_d           = PH_HUNT;
            cnt_d             = '0;
          end else begin
            store_en  = 1'b1;
            store_pos = 4'd0;
            sum_d     = sum_part(4'd0, byte_i);
            phase_d   = PH_LEN;
          end
        end
        PH_LEN: begin
          if (byte_i[6:0] != LenExpect) begin
            push_o.valid      = 1'b1;
            push_o.rec.status = ST_BAD_LEN;
            phase_d           = PH_HUNT;
            cnt_d             = '0;
          end else begin
            store_en  = 1'b1;
            store_pos = 4'd1;
            sum_d     = sum_q + sum_part(4'd1, byte_i);
            cnt_d     = '0;
            phase_d   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          store_en  = 1'b1;
          store_pos = {1'b0, cnt_q[2:0]} + 4'd2;
          sum_d     = sum_q + sum_part(store_pos, byte_i);
          cnt_d     = cnt_q + 4'd1;
          if (cnt_d >= 4'd8) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          push_o.valid = 1'b1;
          phase_d      = PH_HUNT;
          cnt_d        = '0;
          if (byte_i != end_q) begin
            push_o.rec.status = ST_BAD_END;
          end else begin
            // checksum verdict and sign handling are left to the back end
            push_o.rec.status = ST_OK;
            push_o.rec.sum    = sum_q;
            push_o.rec.x_raw  = {frame_q[4][5:0], frame_q[3], frame_q[2][7]};
            push_o.rec.y_raw  = {frame_q[6][4:0], frame_q[5], frame_q[4][7:6]};
            push_o.rec.z_raw  = {frame_q[8][3:0], frame_q[7], frame_q[6][7:5]};
          end
        end
        default: begin
          // hunting, also for any unused phase code
          if (byte_i != start_q) begin
            push_o.valid      = 1'b1;
            push_o.rec.status = ST_BAD_START;
            phase_d           = PH_HUNT;
          end else begin
            phase_d = PH_DEST;
          end
          cnt_d = '0;
        end
      endcase
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      start_q <= StartReset;
      dest_q  <= DestReset;
      end_q   <= EndReset;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (cfg_i.we) begin
        case (cfg_i.idx)
          REG_START: start_q <= cfg_i.data;
          REG_DEST:  dest_q  <= cfg_i.data;
          REG_END:   end_q   <= cfg_i.data;
          default:   ;
        endcase
      end
    end
  end

  // frame bytes and running sum
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (store_en) begin
      frame_q[store_pos] <= byte_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cfr_back.sv
// back end: checksum fold, verdict and sign-magnitude decode
// depends on cfr_pkg
`default_nettype none

module cfr_back
  import cfr_pkg::*;
(
  input  logic       rec_valid_i,
  input  frame_rec_t rec_i,
  input  logic       out_full_i,
  output logic       rec_pop_o,
  output logic       res_push_o,
  output result_t    res_o
);

  logic [FoldW:0] fold1, fold2;
  logic           sum_ok;

  // sign-magnitude to two's complement, negative zero gives zero
  function automatic logic [CoordW-1:0] sm_decode(input logic [CoordW-1:0] raw);
    logic [CoordW-1:0] mag;
    mag = {1'b0, raw[CoordW-2:0]};
    return raw[CoordW-1] ? CoordW'(15'd0 - mag) : mag;
  endfunction

  assign rec_pop_o  = rec_valid_i & ~out_full_i;
  assign res_push_o = rec_pop_o;

  // two folds of the end-around carry
  assign fold1  = {1'b0, rec_i.sum[FoldW-1:0]} + (FoldW+1)'(rec_i.sum[SumW-1:FoldW]);
  assign fold2  = {1'b0, fold1[FoldW-1:0]} + (FoldW+1)'(fold1[FoldW]);
  assign sum_ok = (fold2 == {1'b0, {FoldW{1'b1}}});

  // result word
  always_comb begin
    res_o        = '0;
    res_o.status = rec_i.status;
    if (rec_i.status == ST_OK) begin
      if (!sum_ok) begin
        res_o.status = ST_BAD_SUM;
      end else begin
        res_o.x = sm_decode(rec_i.x_raw);
        res_o.y = sm_decode(rec_i.y_raw);
        res_o.z = sm_decode(rec_i.z_raw);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/coordinate_frame_receiver.sv
// Coordinate frame receiver: one byte word accepted per cycle while full is low.
// A result passes both queues after the byte that ends or rejects a frame
// (front end classifies into a queue, back end folds the checksum into the result queue).
// Full rises only when the queue between front and back end has no room.
// Reset (async, active low) empties both queues, returns to hunting, loads 240, 128, 15.
// top level; depends on cfr_pkg, cfr_fifo, cfr_front and cfr_back
`default_nettype none

module coordinate_frame_receiver
  import cfr_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MidDepth,
  parameter int unsigned OUT_DEPTH = OutDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [ByteW-1:0]         rx_byte_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [2:0]               status_o,
  output logic signed [CoordW-1:0] x_coord_o,
  output logic signed [CoordW-1:0] y_coord_o,
  output logic signed [CoordW-1:0] z_coord_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ByteW-1:0]         cfg_data_i
);

  cfg_wr_t    cfg;
  rec_push_t  front_push;
  frame_rec_t mid_rec;
  logic       mid_full, mid_empty, mid_pop;
  logic       out_full, res_push;
  result_t    res, out_res;
  logic       byte_acc;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign full     = mid_full;
  assign byte_acc = push & ~mid_full;

  // front end
  cfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (byte_acc),
    .byte_i       (rx_byte_i),
    .push_o       (front_push)
  );

  // queue of classified frames
  cfr_fifo #(
    .Width ($bits(frame_rec_t)),
    .Depth (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push.valid),
    .data_i  (front_push.rec),
    .pop_i   (mid_pop),
    .data_o  (mid_rec),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  // back end
  cfr_back u_back (
    .rec_valid_i (~mid_empty),
    .rec_i       (mid_rec),
    .out_full_i  (out_full),
    .rec_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // result queue
  cfr_fifo #(
    .Width ($bits(result_t)),
    .Depth (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .pop_i   (pop),
    .data_o  (out_res),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign status_o  = out_res.status;
  assign x_coord_o = out_res.x;
  assign y_coord_o = out_res.y;
  assign z_coord_o = out_res.z;

endmodule

`default_nettype wire

>>> rtl/cfr_checker.sv
// port-level checks of the coordinate frame receiver, bound to the top level
// depends on cfr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cfr_checker
  import cfr_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic [2:0]               status_o,
  input logic signed [CoordW-1:0] x_coord_o,
  input logic signed [CoordW-1:0] y_coord_o,
  input logic signed [CoordW-1:0] z_coord_o
);

  localparam logic [CoordW-1:0] NegZero = {1'b1, {(CoordW-1){1'b0}}};

  logic coords_zero;
  logic coords_neg_zero;

  // coordinate summaries of the waiting word
  assign coords_zero     = (x_coord_o == '0) && (y_coord_o == '0) && (z_coord_o == '0);
  assign coords_neg_zero = (x_coord_o == NegZero) || (y_coord_o == NegZero) ||
                           (z_coord_o == NegZero);

  // error words carry no coordinates
  `ASSERT_STD(a_err_zero, (!empty && status_o != ST_OK) |-> coords_zero)

  // only defined status codes
  `ASSERT_STD(a_status_range, !empty |-> (status_o <= ST_BAD_SUM))

  // negative zero never leaves the block
  `ASSERT_STD(a_no_neg_zero, !empty |-> !coords_neg_zero)

  // the status and x of a waiting word hold while not taken
  `ASSERT_STD(a_hold, (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(x_coord_o)))

endmodule

bind coordinate_frame_receiver cfr_checker u_cfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .status_o  (status_o),
  .x_coord_o (x_coord_o),
  .y_coord_o (y_coord_o),
  .z_coord_o (z_coord_o)
);

`default_nettype wire

>>> sim/coordinate_frame_receiver_tb.sv
// self-checking testbench for the coordinate frame receiver: byte words in, result words out
// predicts every result from its own deframer model; depends on cfr_pkg and the rtl top level
`default_nettype none

module coordinate_frame_receiver_tb;
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    HUNT_START,
    WANT_DEST,
    WANT_LEN,
    IN_BODY,
    WANT_END
  } rx_phase_e;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic [19:0]        SumOnes  = 20'hFFFFF;
  localparam int                 IdlePct  = 34;
  localparam int                 HoldLen  = 300;
  localparam int                 HoldAt   = 40;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     push       = 1'b0;
  logic                     full;
  logic [ByteW-1:0]         rx_byte_i  = '0;
  logic                     empty;
  logic                     pop        = 1'b0;
  logic [2:0]               status_o;
  logic signed [CoordW-1:0] x_coord_o;
  logic signed [CoordW-1:0] y_coord_o;
  logic signed [CoordW-1:0] z_coord_o;
  logic                     cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i  = REG_START;
  logic [ByteW-1:0]         cfg_data_i = '0;

  // deframer copy: register values and receive state
  logic [ByteW-1:0] sof_byte  = StartReset;
  logic [ByteW-1:0] addr_byte = DestReset;
  logic [ByteW-1:0] eof_byte  = EndReset;
  rx_phase_e        rx_phase  = HUNT_START;
  logic [9:0][7:0]  frame_buf = '0;
  logic [3:0]       body_cnt  = '0;

  logic [ByteW-1:0] byte_queue[$];
  result_t          frames_due[$];
  int               errors    = 0;
  int               got       = 0;
  bit               no_gaps   = 1'b0;

  coordinate_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status_o),
    .x_coord_o  (x_coord_o),
    .y_coord_o  (y_coord_o),
    .z_coord_o  (z_coord_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // 20-bit end-around-carry sum of the four checksum fields over D0..D9
  function automatic logic [19:0] frame_total(input logic [9:0][7:0] d);
    logic [21:0] s;
    s = 22'({d[2][3:0], d[1], d[0]}) + 22'({d[4], d[3], d[2][7:4]})
      + 22'({d[7][3:0], d[6], d[5]}) + 22'({d[9], d[8], d[7][7:4]});
    // two folds always bring the sum back into 20 bits
    s = 22'(s[21:20]) + 22'(s[19:0]);
    s = 22'(s[21:20]) + 22'(s[19:0]);
    return s[19:0];
  endfunction

  // sign-magnitude to two's complement, negative zero gives zero
  function automatic logic signed [CoordW-1:0] from_sign_mag(input logic [14:0] raw);
    logic [14:0] m;
    m = {1'b0, raw[13:0]};
    return raw[14] ? (15'd0 - m) : m;
  endfunction

  // advance the deframer by one accepted byte word, queue any result it gives
  function automatic void track_byte(input logic [7:0] b);
    result_t r;
    bit      done;
    r.status = ST_OK;
    r.x      = '0;
    r.y      = '0;
    r.z      = '0;
    done     = 1'b0;
    case (rx_phase)
      WANT_DEST: begin
        if (b != addr_byte) begin
          r.status = ST_BAD_DEST;
          done     = 1'b1;
        end else begin
          frame_buf[0] = b;
          rx_phase     = WANT_LEN;
        end
      end
      WANT_LEN: begin
        if (b[6:0] != LenExpect) begin
          r.status = ST_BAD_LEN;
          done     = 1'b1;
        end else begin
          frame_buf[1] = b;
          body_cnt     = '0;
          rx_phase     = IN_BODY;
        end
      end
      IN_BODY: begin
        frame_buf[2 + body_cnt[2:0]] = b;
        body_cnt = body_cnt + 4'd1;
        if (body_cnt >= 4'd8) rx_phase = WANT_END;
      end
      WANT_END: begin
        done = 1'b1;
        if (b != eof_byte) begin
          r.status = ST_BAD_END;
        end else if (frame_total(frame_buf) != SumOnes) begin
          r.status = ST_BAD_SUM;
        end else begin
          r.x = from_sign_mag({frame_buf[4][5:0], frame_buf[3], frame_buf[2][7]});
          r.y = from_sign_mag({frame_buf[6][4:0], frame_buf[5], frame_buf[4][7:6]});
          r.z = from_sign_mag({frame_buf[8][3:0], frame_buf[7], frame_buf[6][7:5]});
        end
      end
      default: begin
        if (b != sof_byte) begin
          r.status = ST_BAD_START;
          done     = 1'b1;
        end else begin
          rx_phase = WANT_DEST;
          body_cnt = '0;
        end
      end
    endcase
    if (done) begin
      frames_due.push_back(r);
      rx_phase = HUNT_START;
      body_cnt = '0;
    end
  endfunction

  // overwrite one checksum field of the payload so that the frame sums to all ones
  function automatic logic [63:0] seal_body(input logic [63:0] body, input logic [7:0] d0,
                                            input logic [7:0] d1, input bit via_f2);
    logic [63:0] b;
    logic [19:0] rest;
    b = body;
    if (via_f2) b[23:4] = '0;
    else b[63:44] = '0;
    rest = frame_total({b, d1, d0});
    if (via_f2) b[23:4] = ~rest;
    else b[63:44] = ~rest;
    return b;
  endfunction

  // coordinates lean towards the extremes and negative zero
  function automatic logic [14:0] pick_coord();
    case ($urandom_range(7))
      0:       return 15'h3FFF;
      1:       return 15'h7FFF;
      2:       return 15'h0000;
      3:       return 15'h4000;
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_START: sof_byte  = val;
      REG_DEST:  addr_byte = val;
      REG_END:   eof_byte  = val;
      default:   ;
    endcase
  endtask

  // mostly well-formed frames with random content, some broken frames and noise
  task automatic add_traffic(input int n);
    int               added;
    int               pick;
    int               cut;
    int               i;
    logic [63:0]      body;
    logic [7:0]       len;
    logic [11:0][7:0] frm;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      body = {$urandom, $urandom};
      body[51:7] = {pick_coord(), pick_coord(), pick_coord()};
      len  = {1'($urandom), LenExpect};
      body = seal_body(body, addr_byte, len, 1'($urandom));
      cut  = 12;
      if (pick >= 55 && pick < 63) body = body ^ (64'd1 << $urandom_range(63));
      frm = {eof_byte, body, len, addr_byte, sof_byte};
      if (pick >= 63 && pick < 70) begin
        frm[11] = eof_byte ^ 8'($urandom_range(1, 255));
      end else if (pick >= 70 && pick < 76) begin
        frm[2] = {1'($urandom), LenExpect ^ 7'($urandom_range(1, 127))};
        cut    = $urandom_range(3, 12);
      end else if (pick >= 76 && pick < 82) begin
        frm[1] = addr_byte ^ 8'($urandom_range(1, 255));
        cut    = $urandom_range(2, 12);
      end else if (pick >= 82 && pick < 90) begin
        cut = $urandom_range(1, 11);
      end else if (pick >= 90) begin
        cut = $urandom_range(1, 4);
        for (i = 0; i < cut; i++) frm[i] = 8'($urandom);
      end
      for (i = 0; i < cut; i++) byte_queue.push_back(frm[i]);
      added += cut;
    end
  endtask

  task automatic queue_frame(input logic [7:0] len, input logic [63:0] body);
    logic [11:0][7:0] frm;
    int               i;
    frm = {eof_byte, body, len, addr_byte, sof_byte};
    for (i = 0; i < 12; i++) byte_queue.push_back(frm[i]);
  endtask

  // wait until every word is in and every result is out, then let the pipeline settle
  task automatic drain();
    while (byte_queue.size() != 0 || frames_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // sender: offers the oldest pending byte word, holds it while full
  always @(posedge clk_i) begin : drive
    logic       next_push;
    logic [7:0] next_byte;
    next_byte = rx_byte_i;
    if (!rst_ni) begin
      next_push = 1'b0;
    end else begin
      if (push && !full) begin
        track_byte(rx_byte_i);
        void'(byte_queue.pop_front());
      end
      if (push && full) begin
        next_push = 1'b1;
      end else if (byte_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IdlePct)) begin
        next_push = 1'b1;
        next_byte = byte_queue[0];
      end else begin
        next_push = 1'b0;
      end
    end
    push      <= next_push;
    rx_byte_i <= next_byte;
  end

  // receiver: checks each popped result word against the oldest prediction
  always @(posedge clk_i) begin : watch
    result_t want;
    int      hold_left;
    bit      held;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got++;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result: status %0d x %0d y %0d z %0d", $time,
                   status_o, x_coord_o, y_coord_o, z_coord_o);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
            errors++;
          end
          if (x_coord_o !== want.x) begin
            $display("%0t: x_coord expected %0d got %0d", $time, want.x, x_coord_o);
            errors++;
          end
          if (y_coord_o !== want.y) begin
            $display("%0t: y_coord expected %0d got %0d", $time, want.y, y_coord_o);
            errors++;
          end
          if (z_coord_o !== want.z) begin
            $display("%0t: z_coord expected %0d got %0d", $time, want.z, z_coord_o);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!held && got == HoldAt) begin
        held      = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_gaps || $urandom_range(99) >= IdlePct;
      end
    end
  end

  initial begin
    #4000000;
    $display("coordinate_frame_receiver_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset codes: noise in the hunt, a frame with -max and negative zero, bad dest, bad length
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    queue_frame(8'hE0, seal_body({12'h000, 15'h1234, 15'h4000, 15'h7FFF, 7'h00},
                                 addr_byte, 8'hE0, 1'b0));
    byte_queue.push_back(sof_byte);
    byte_queue.push_back(~addr_byte);
    byte_queue.push_back(sof_byte);
    byte_queue.push_back(addr_byte);
    byte_queue.push_back(8'h5F);
    add_traffic(130);
    drain();

    // start and end codes at their low extreme, destination at its high extreme
    write_reg(REG_START, 8'h00);
    write_reg(REG_DEST, 8'hFF);
    write_reg(REG_END, 8'h00);
    add_traffic(160);
    drain();

    // start and end codes at their high extreme, destination at its low extreme, both sides running flat out
    no_gaps = 1'b1;
    write_reg(REG_START, 8'hFF);
    write_reg(REG_DEST, 8'h00);
    write_reg(REG_END, 8'hFF);
    add_traffic(160);
    drain();
    no_gaps = 1'b0;

    // random codes; a write to the spare index must leave them alone
    write_reg(REG_START, 8'($urandom));
    write_reg(REG_DEST, 8'($urandom));
    write_reg(REG_END, 8'($urandom));
    write_reg(RegSpare, 8'($urandom));
    add_traffic(180);
    drain();

    if (errors == 0) begin
      $display("coordinate_frame_receiver_tb OK");
    end else begin
      $display("coordinate_frame_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
